### rtl/iff8svx_pkg.sv
// types, codes and constants for the 8svx stream parser
// no dependencies; used by iff_8svx_stream_parser_core
`default_nettype none

package iff8svx_pkg;

    // big-endian four-character tags
    localparam logic [31:0] TAG_FORM = 32'h464F_524D;
    localparam logic [31:0] TAG_8SVX = 32'h3853_5658;
    localparam logic [31:0] TAG_VHDR = 32'h5648_4452;
    localparam logic [31:0] TAG_BODY = 32'h424F_4459;

    localparam logic [4:0] WORD_BYTES  = 5'd4;
    localparam logic [4:0] VHDR_MIN    = 5'd18;
    localparam logic [4:0] VHDR_RATE_HI = 5'd12;
    localparam logic [4:0] VHDR_RATE_LO = 5'd13;
    localparam logic [7:0] SAMPLE_BIAS = 8'd128;

    // result queue geometry
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_DEPTH = 2 ** QUEUE_PTR_W;

    typedef enum logic [3:0] {
        PH_FORM  = 4'd0,
        PH_LEN   = 4'd1,
        PH_TYPE  = 4'd2,
        PH_CID   = 4'd3,
        PH_CSIZE = 4'd4,
        PH_VHDR  = 4'd5,
        PH_BODY  = 4'd6,
        PH_SKIP  = 4'd7,
        PH_IDLE  = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        CK_OTHER = 2'd0,
        CK_VHDR  = 2'd1,
        CK_BODY  = 2'd2
    } t_chunk_kind;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BAD_FORM   = 3'd1;
    localparam logic [2:0] ERR_BAD_TYPE   = 3'd2;
    localparam logic [2:0] ERR_TRUNCATED  = 3'd3;
    localparam logic [2:0] ERR_NO_BODY    = 3'd4;
    localparam logic [2:0] ERR_SHORT_VHDR = 3'd5;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        kind;
        logic signed [7:0] sample;
        logic [15:0]       sample_rate;
        logic [31:0]       sample_count;
        logic [2:0]        error_code;
        logic              last_in_run;
    } t_out_item;

    // phases in which the form length counts down
    function automatic logic in_form(input t_phase ph);
        in_form = (ph >= PH_TYPE) && (ph <= PH_SKIP);
    endfunction

endpackage

`default_nettype wire

### rtl/iff_8svx_stream_parser_core.sv
// 8svx byte stream parser: header walk, sample emission and result queue
// depends on iff8svx_pkg
//
// channel  dir  handshake                 payload
// in       in   i_in_valid / o_in_ready   i_in  (byte_value, last_byte)
// out      out  o_out_valid / i_out_ready o_out (kind, sample, rate, count, error, last)
//
// one byte is taken per cycle while o_in_ready is high; the parse state updates on the transfer edge
// each byte queues zero, one or two results in a four-entry result queue
// results leave one per cycle while i_out_ready is high, so a byte that yields two
// needs two output transfers; input stalls only while fewer than two queue slots are free
// synchronous active-low reset returns the parser to the FORM magic and
// empties the queue; a final byte does the same for the parse state
`default_nettype none

module iff_8svx_stream_parser_core (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  wire iff8svx_pkg::t_in_item i_in,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output iff8svx_pkg::t_out_item  o_out
);

    // parse state
    iff8svx_pkg::t_phase      r_phase, n_phase;
    logic [4:0]               r_idx, n_idx;
    logic [31:0]              r_shift, n_shift;
    logic [31:0]              r_form, n_form;
    iff8svx_pkg::t_chunk_kind r_ckind, n_ckind;
    logic [31:0]              r_chunk, n_chunk;
    logic [15:0]              r_rate, n_rate;
    logic [31:0]              r_count, n_count;
    logic                     r_body, n_body;

    // per-byte result flags
    logic        s_sample;
    logic        s_fail;
    logic        s_done;
    logic [2:0]  s_err;
    logic [15:0] s_rate;
    logic [31:0] s_count;

    logic [31:0] w_word;
    logic [4:0]  w_idx_inc;
    logic        w_word_done;
    logic [7:0]  w_byte;
    logic        w_in_fire;
    logic        w_out_fire;

    // result queue
    iff8svx_pkg::t_out_item r_queue [iff8svx_pkg::QUEUE_DEPTH];
    logic [iff8svx_pkg::QUEUE_PTR_W-1:0] r_wr, r_rd;
    logic [iff8svx_pkg::QUEUE_PTR_W:0]   r_fill;
    iff8svx_pkg::t_out_item w_res_a, w_res_b, w_first;
    logic        w_push_a, w_push_b;
    logic [1:0]  w_push_n;

    assign w_byte     = i_in.byte_value;
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_fire = o_out_valid && i_out_ready;
    assign w_word     = {r_shift[23:0], w_byte};
    assign w_idx_inc  = r_idx + 5'd1;
    assign w_word_done = (w_idx_inc >= iff8svx_pkg::WORD_BYTES);

    // next parse state for the byte on the input
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_shift = r_shift;
        n_form  = r_form;
        n_ckind = r_ckind;
        n_chunk = r_chunk;
        n_rate  = r_rate;
        n_count = r_count;
        n_body  = r_body;
        s_sample = 1'b0;
        s_fail   = 1'b0;
        s_done   = 1'b0;
        s_err    = iff8svx_pkg::ERR_NONE;
        s_rate   = '0;
        s_count  = '0;

        if (iff8svx_pkg::in_form(r_phase)) begin
            n_form = r_form - 32'd1;
        end

        case (r_phase)
            iff8svx_pkg::PH_FORM: begin
                n_shift = w_word;
                n_idx   = w_word_done ? 5'd0 : w_idx_inc;
                if (w_word_done) begin
                    if (w_word != iff8svx_pkg::TAG_FORM) begin
                        s_fail = 1'b1;
                        s_err  = iff8svx_pkg::ERR_BAD_FORM;
                    end else begin
                        n_phase = iff8svx_pkg::PH_LEN;
                    end
                end
            end
            iff8svx_pkg::PH_LEN: begin
                n_shift = w_word;
                n_idx   = w_word_done ? 5'd0 : w_idx_inc;
                if (w_word_done) begin
                    n_form = w_word;
                    if (w_word == 32'd0) begin
                        s_fail = 1'b1;
                        s_err  = iff8svx_pkg::ERR_TRUNCATED;
                    end else begin
                        n_phase = iff8svx_pkg::PH_TYPE;
                    end
                end
            end
            iff8svx_pkg::PH_TYPE: begin
                n_shift = w_word;
                n_idx   = w_word_done ? 5'd0 : w_idx_inc;
                if (w_word_done) begin
                    if (w_word != iff8svx_pkg::TAG_8SVX) begin
                        s_fail = 1'b1;
                        s_err  = iff8svx_pkg::ERR_BAD_TYPE;
                    end else begin
                        n_phase = iff8svx_pkg::PH_CID;
                    end
                end
            end
            iff8svx_pkg::PH_CID: begin
                n_shift = w_word;
                n_idx   = w_word_done ? 5'd0 : w_idx_inc;
                if (w_word_done) begin
                    if (w_word == iff8svx_pkg::TAG_VHDR) begin
                        n_ckind = iff8svx_pkg::CK_VHDR;
                    end else if (w_word == iff8svx_pkg::TAG_BODY) begin
                        n_ckind = iff8svx_pkg::CK_BODY;
                        n_body  = 1'b1;
                    end else begin
                        n_ckind = iff8svx_pkg::CK_OTHER;
                    end
                    n_phase = iff8svx_pkg::PH_CSIZE;
                end
            end
            iff8svx_pkg::PH_CSIZE: begin
                n_shift = w_word;
                n_idx   = w_word_done ? 5'd0 : w_idx_inc;
                if (w_word_done) begin
                    n_chunk = w_word;
                    if (r_ckind == iff8svx_pkg::CK_VHDR &&
                        w_word < {27'd0, iff8svx_pkg::VHDR_MIN}) begin
                        s_fail = 1'b1;
                        s_err  = iff8svx_pkg::ERR_SHORT_VHDR;
                    end else if (w_word == 32'd0) begin
                        n_phase = iff8svx_pkg::PH_CID;
                    end else if (r_ckind == iff8svx_pkg::CK_VHDR) begin
                        n_phase = iff8svx_pkg::PH_VHDR;
                    end else if (r_ckind == iff8svx_pkg::CK_BODY) begin
                        n_phase = iff8svx_pkg::PH_BODY;
                    end else begin
                        n_phase = iff8svx_pkg::PH_SKIP;
                    end
                end
            end
            iff8svx_pkg::PH_VHDR: begin
                // count in bytes 0..3, rate in bytes 12..13
                if (r_idx < iff8svx_pkg::WORD_BYTES) begin
                    n_count = {r_count[23:0], w_byte};
                end else if (r_idx == iff8svx_pkg::VHDR_RATE_HI ||
                             r_idx == iff8svx_pkg::VHDR_RATE_LO) begin
                    n_rate = {r_rate[7:0], w_byte};
                end
                if (r_idx < iff8svx_pkg::VHDR_MIN) begin
                    n_idx = w_idx_inc;
                end
                if (r_chunk == 32'd1) begin
                    n_idx = 5'd0;
                end
                n_chunk = r_chunk - 32'd1;
                if (r_chunk == 32'd1) begin
                    n_phase = iff8svx_pkg::PH_CID;
                end
            end
            iff8svx_pkg::PH_BODY: begin
                s_sample = 1'b1;
                n_chunk  = r_chunk - 32'd1;
                if (r_chunk == 32'd1) begin
                    n_phase = iff8svx_pkg::PH_CID;
                end
            end
            iff8svx_pkg::PH_SKIP: begin
                n_chunk = r_chunk - 32'd1;
                if (r_chunk == 32'd1) begin
                    n_phase = iff8svx_pkg::PH_CID;
                end
            end
            default: begin
            end
        endcase

        if (s_fail) begin
            n_phase = iff8svx_pkg::PH_IDLE;
        end

        // form fully consumed on this byte
        if (iff8svx_pkg::in_form(r_phase) && r_form == 32'd1 &&
            iff8svx_pkg::in_form(n_phase)) begin
            if (n_phase == iff8svx_pkg::PH_CID && n_idx == 5'd0) begin
                if (n_body) begin
                    s_done  = 1'b1;
                    s_rate  = n_rate;
                    s_count = n_count;
                end else begin
                    s_fail = 1'b1;
                    s_err  = iff8svx_pkg::ERR_NO_BODY;
                end
            end else begin
                s_fail = 1'b1;
                s_err  = iff8svx_pkg::ERR_TRUNCATED;
            end
            n_phase = iff8svx_pkg::PH_IDLE;
        end

        // final byte: flag an unfinished parse, then start afresh
        if (i_in.last_byte) begin
            if (n_phase != iff8svx_pkg::PH_IDLE) begin
                s_fail = 1'b1;
                s_err  = iff8svx_pkg::ERR_TRUNCATED;
            end
            n_phase = iff8svx_pkg::PH_FORM;
            n_idx   = '0;
            n_shift = '0;
            n_form  = '0;
            n_ckind = iff8svx_pkg::CK_OTHER;
            n_chunk = '0;
            n_rate  = '0;
            n_count = '0;
            n_body  = 1'b0;
        end
    end

    // result items for the byte on the input
    always_comb begin
        w_res_a.kind         = iff8svx_pkg::KIND_SAMPLE;
        w_res_a.sample       = w_byte - iff8svx_pkg::SAMPLE_BIAS;
        w_res_a.sample_rate  = '0;
        w_res_a.sample_count = '0;
        w_res_a.error_code   = iff8svx_pkg::ERR_NONE;
        w_res_a.last_in_run  = !(s_fail || s_done);

        w_res_b.kind         = s_done ? iff8svx_pkg::KIND_DONE : iff8svx_pkg::KIND_ERROR;
        w_res_b.sample       = '0;
        w_res_b.sample_rate  = s_rate;
        w_res_b.sample_count = s_count;
        w_res_b.error_code   = s_done ? iff8svx_pkg::ERR_NONE : s_err;
        w_res_b.last_in_run  = 1'b1;

        w_push_a = w_in_fire && s_sample;
        w_push_b = w_in_fire && (s_fail || s_done);
        w_push_n = {1'b0, w_push_a} + {1'b0, w_push_b};
        w_first  = w_push_a ? w_res_a : w_res_b;
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= iff8svx_pkg::PH_FORM;
            r_idx   <= '0;
            r_shift <= '0;
            r_form  <= '0;
            r_ckind <= iff8svx_pkg::CK_OTHER;
            r_chunk <= '0;
            r_rate  <= '0;
            r_count <= '0;
            r_body  <= 1'b0;
        end else if (w_in_fire) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_shift <= n_shift;
            r_form  <= n_form;
            r_ckind <= n_ckind;
            r_chunk <= n_chunk;
            r_rate  <= n_rate;
            r_count <= n_count;
            r_body  <= n_body;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push_n != 2'd0) begin
            r_queue[r_wr] <= w_first;
        end
        if (w_push_n == 2'd2) begin
            r_queue[r_wr + 1'b1] <= w_res_b;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= r_wr + w_push_n[iff8svx_pkg::QUEUE_PTR_W-1:0];
            r_rd   <= r_rd + {{(iff8svx_pkg::QUEUE_PTR_W-1){1'b0}}, w_out_fire};
            r_fill <= r_fill + {{(iff8svx_pkg::QUEUE_PTR_W-1){1'b0}}, w_push_n}
                      - {{iff8svx_pkg::QUEUE_PTR_W{1'b0}}, w_out_fire};
        end
    end

    // room for two results keeps the input open
    assign o_in_ready  = (r_fill <= (iff8svx_pkg::QUEUE_PTR_W + 1)'(iff8svx_pkg::QUEUE_DEPTH - 2));
    assign o_out_valid = (r_fill != '0);
    assign o_out       = r_queue[r_rd];

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (iff8svx_pkg::QUEUE_PTR_W + 1)'(iff8svx_pkg::QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_in.last_byte) |=> (r_phase == iff8svx_pkg::PH_FORM && !r_body))
        else $error("final byte did not restart the parse");

    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && r_phase == iff8svx_pkg::PH_IDLE && !i_in.last_byte)
        |-> (w_push_n == 2'd0))
        else $error("result produced after parse finished");

    // a form that runs out inside vhdr leaves the index where it stopped
    a_idx_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != iff8svx_pkg::PH_VHDR && r_phase != iff8svx_pkg::PH_IDLE)
        |-> (r_idx < iff8svx_pkg::WORD_BYTES))
        else $error("field byte index out of range outside vhdr");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.kind != iff8svx_pkg::KIND_SAMPLE) |-> o_out.last_in_run)
        else $error("status result not marked last in run");

endmodule

`default_nettype wire

### tb/iff_8svx_stream_parser_checker.sv
// result checker for the 8svx stream parser: watches both channels and
// predicts each transfer's results from its own copy of the parse state
// depends on iff8svx_pkg
`timescale 1ns / 1ps

module iff_8svx_stream_parser_checker
    import iff8svx_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    input  wire       i_in_ready,
    input  t_in_item  i_in,
    input  wire       i_out_valid,
    input  wire       i_out_ready,
    input  t_out_item i_out,
    output int        o_results_due,
    output int        o_mismatch_count
);

    // predicted parse state
    t_phase      prs_phase;
    logic [4:0]  word_idx;
    logic [31:0] word_acc;
    logic [31:0] form_left;
    t_chunk_kind prs_kind;
    logic [31:0] chunk_left;
    logic [15:0] rate_held;
    logic [31:0] count_held;
    logic        body_seen;

    // results still owed by the block, oldest first
    t_out_item results_due[$];
    // results raised by the byte being predicted
    t_out_item byte_results[$];

    task automatic clear_parser();
        prs_phase  = PH_FORM;
        word_idx   = '0;
        word_acc   = '0;
        form_left  = '0;
        prs_kind   = CK_OTHER;
        chunk_left = '0;
        rate_held  = '0;
        count_held = '0;
        body_seen  = 1'b0;
    endtask

    task automatic note_result(input logic [1:0] kind, input logic [7:0] smp,
                               input logic [15:0] rate, input logic [31:0] cnt,
                               input logic [2:0] err);
        t_out_item r;
        r.kind         = kind;
        r.sample       = smp;
        r.sample_rate  = rate;
        r.sample_count = cnt;
        r.error_code   = err;
        r.last_in_run  = 1'b0;
        byte_results.push_back(r);
    endtask

    task automatic raise_error(input logic [2:0] err);
        note_result(KIND_ERROR, 8'd0, 16'd0, 32'd0, err);
        prs_phase = PH_IDLE;
    endtask

    // shift a byte into the word accumulator, true once four are in
    function automatic logic take_word(input logic [7:0] b);
        word_acc = {word_acc[23:0], b};
        word_idx = word_idx + 5'd1;
        if (word_idx >= WORD_BYTES) begin
            word_idx = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic counts_form(input t_phase ph);
        return (ph >= PH_TYPE) && (ph <= PH_SKIP);
    endfunction

    task automatic chunk_byte();
        chunk_left = chunk_left - 32'd1;
        if (chunk_left == 32'd0)
            prs_phase = PH_CID;
    endtask

    // work out the results of one byte transfer
    task automatic predict_parse(input t_in_item item);
        logic [7:0] b;
        t_out_item  r;
        b = item.byte_value;
        byte_results.delete();

        if (counts_form(prs_phase))
            form_left = form_left - 32'd1;

        case (prs_phase)
            PH_FORM: begin
                if (take_word(b)) begin
                    if (word_acc != TAG_FORM)
                        raise_error(ERR_BAD_FORM);
                    else
                        prs_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if (take_word(b)) begin
                    form_left = word_acc;
                    if (form_left == 32'd0)
                        raise_error(ERR_TRUNCATED);
                    else
                        prs_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                if (take_word(b)) begin
                    if (word_acc != TAG_8SVX)
                        raise_error(ERR_BAD_TYPE);
                    else
                        prs_phase = PH_CID;
                end
            end
            PH_CID: begin
                if (take_word(b)) begin
                    if (word_acc == TAG_VHDR) begin
                        prs_kind = CK_VHDR;
                    end else if (word_acc == TAG_BODY) begin
                        prs_kind  = CK_BODY;
                        body_seen = 1'b1;
                    end else begin
                        prs_kind = CK_OTHER;
                    end
                    prs_phase = PH_CSIZE;
                end
            end
            PH_CSIZE: begin
                if (take_word(b)) begin
                    chunk_left = word_acc;
                    if (prs_kind == CK_VHDR && chunk_left < 32'(VHDR_MIN))
                        raise_error(ERR_SHORT_VHDR);
                    else if (chunk_left == 32'd0)
                        prs_phase = PH_CID;
                    else if (prs_kind == CK_VHDR)
                        prs_phase = PH_VHDR;
                    else if (prs_kind == CK_BODY)
                        prs_phase = PH_BODY;
                    else
                        prs_phase = PH_SKIP;
                end
            end
            PH_VHDR: begin
                // count in bytes 0..3, rate in bytes 12..13
                if (word_idx < WORD_BYTES)
                    count_held = {count_held[23:0], b};
                else if (word_idx == VHDR_RATE_HI || word_idx == VHDR_RATE_LO)
                    rate_held = {rate_held[7:0], b};
                if (word_idx < VHDR_MIN)
                    word_idx = word_idx + 5'd1;
                if (chunk_left == 32'd1)
                    word_idx = '0;
                chunk_byte();
            end
            PH_BODY: begin
                note_result(KIND_SAMPLE, b - SAMPLE_BIAS, 16'd0, 32'd0, ERR_NONE);
                chunk_byte();
            end
            PH_SKIP: begin
                chunk_byte();
            end
            default: begin
            end
        endcase

        // form length used up
        if (counts_form(prs_phase) && form_left == 32'd0) begin
            if (prs_phase == PH_CID && word_idx == 5'd0) begin
                if (body_seen) begin
                    note_result(KIND_DONE, 8'd0, rate_held, count_held, ERR_NONE);
                    prs_phase = PH_IDLE;
                end else begin
                    raise_error(ERR_NO_BODY);
                end
            end else begin
                raise_error(ERR_TRUNCATED);
            end
        end

        // final byte of the file starts a fresh parse
        if (item.last_byte) begin
            if (prs_phase != PH_IDLE)
                raise_error(ERR_TRUNCATED);
            clear_parser();
        end

        for (int k = 0; k < byte_results.size(); k++) begin
            r = byte_results[k];
            r.last_in_run = (k == byte_results.size() - 1);
            results_due.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            o_mismatch_count++;
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (results_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, got kind %0d sample %0d",
                     $time, got.kind, got.sample,
                     " rate %0d count %0d error %0d last %0b",
                     got.sample_rate, got.sample_count, got.error_code, got.last_in_run);
            o_mismatch_count++;
        end else begin
            want = results_due.pop_front();
            check_field("kind", 32'(want.kind), 32'(got.kind));
            check_field("sample", 32'($unsigned(want.sample)), 32'($unsigned(got.sample)));
            check_field("sample_rate", 32'(want.sample_rate), 32'(got.sample_rate));
            check_field("sample_count", want.sample_count, got.sample_count);
            check_field("error_code", 32'(want.error_code), 32'(got.error_code));
            check_field("last_in_run", 32'(want.last_in_run), 32'(got.last_in_run));
        end
    endtask

    // sample both channels on each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            results_due.delete();
            o_mismatch_count = 0;
        end else begin
            if (i_out_valid && i_out_ready)
                check_result(i_out);
            if (i_in_valid && i_in_ready)
                predict_parse(i_in);
        end
        o_results_due <= results_due.size();
    end

endmodule

### tb/tb_iff_8svx_stream_parser_core.sv
// testbench top for the 8svx stream parser: feeds well-formed and damaged
// files with random stalls on both sides and gives the verdict
// depends on iff8svx_pkg, iff_8svx_stream_parser_core and the checker
`timescale 1ns / 1ps

module tb_iff_8svx_stream_parser_core;
    import iff8svx_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int BYTE_TARGET = 850;

    typedef enum int {
        FILE_GOOD,
        FILE_BAD_MAGIC,
        FILE_BAD_TYPE,
        FILE_ZERO_LEN,
        FILE_LEN_OFF,
        FILE_SHORT_VHDR,
        FILE_NO_BODY,
        FILE_CUT_SHORT,
        FILE_NOISE
    } t_file_flavour;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;
    int        results_due;
    int        mismatch_count;

    logic [7:0] file_bytes[$];
    int         bytes_sent;

    iff_8svx_stream_parser_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    iff_8svx_stream_parser_checker u_parser_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_in             (in_item),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_out            (out_item),
        .o_results_due    (results_due),
        .o_mismatch_count (mismatch_count)
    );

    // 50 MHz clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // idle cycles before the next transfer, with calm stretches now and then
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    task automatic push_word(input logic [31:0] w);
        for (int k = 3; k >= 0; k--)
            file_bytes.push_back(w[8*k +: 8]);
    endtask

    // one byte transfer on the input channel
    int send_calm = 0;

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid           <= 1'b1;
        in_item.byte_value <= b;
        in_item.last_byte  <= last;
        do @(posedge clk); while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int k = 0; k < file_bytes.size(); k++)
            send_byte(file_bytes[k], k == file_bytes.size() - 1);
    endtask

    // random file, mostly well-formed, otherwise damaged in one way
    task automatic build_file();
        t_file_flavour flavour;
        t_chunk_kind   kinds [4];
        int            sizes [4];
        int            n_chunks;
        logic [31:0]   form_len;
        logic [31:0]   magic;
        logic [31:0]   form_type;
        int            cut;
        logic          body_added;

        if ($urandom_range(0, 99) < 55)
            flavour = FILE_GOOD;
        else
            flavour = t_file_flavour'($urandom_range(FILE_BAD_MAGIC, FILE_NOISE));
        file_bytes.delete();

        if (flavour == FILE_NOISE) begin
            repeat ($urandom_range(1, 8))
                file_bytes.push_back(8'($urandom));
        end else begin
            // chunk plan
            n_chunks   = $urandom_range(1, 4);
            body_added = 1'b0;
            form_len   = 32'd4;
            for (int c = 0; c < n_chunks; c++) begin
                kinds[c] = t_chunk_kind'($urandom_range(0, 2));
                if (flavour == FILE_NO_BODY && kinds[c] == CK_BODY)
                    kinds[c] = CK_OTHER;
                if (c == n_chunks - 1 && !body_added && flavour != FILE_NO_BODY)
                    kinds[c] = CK_BODY;
                if (flavour == FILE_SHORT_VHDR && c == 0)
                    kinds[c] = CK_VHDR;
                if (kinds[c] == CK_BODY)
                    body_added = 1'b1;
                case (kinds[c])
                    CK_VHDR: begin
                        sizes[c] = (flavour == FILE_SHORT_VHDR) ? $urandom_range(0, 17)
                                                                : $urandom_range(18, 22);
                    end
                    CK_BODY: begin
                        sizes[c] = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40)
                                                               : $urandom_range(0, 10);
                    end
                    default: begin
                        sizes[c] = $urandom_range(0, 5);
                    end
                endcase
                form_len = form_len + 32'(8 + sizes[c]);
            end

            // header damage
            magic     = TAG_FORM;
            form_type = TAG_8SVX;
            if (flavour == FILE_BAD_MAGIC)
                magic = magic ^ (32'd1 << $urandom_range(0, 31));
            if (flavour == FILE_BAD_TYPE)
                form_type = form_type ^ (32'd1 << $urandom_range(0, 31));
            if (flavour == FILE_ZERO_LEN)
                form_len = 32'd0;
            if (flavour == FILE_LEN_OFF) begin
                if ($urandom_range(0, 3) == 0)
                    form_len = $urandom;
                else if ($urandom_range(0, 1) == 0)
                    form_len = form_len + $urandom_range(1, 6);
                else
                    form_len = form_len - $urandom_range(1, 6);
            end

            push_word(magic);
            push_word(form_len);
            push_word(form_type);
            for (int c = 0; c < n_chunks; c++) begin
                case (kinds[c])
                    CK_VHDR: push_word(TAG_VHDR);
                    CK_BODY: push_word(TAG_BODY);
                    default: push_word($urandom);
                endcase
                push_word(32'(sizes[c]));
                repeat (sizes[c])
                    file_bytes.push_back(8'($urandom));
            end
            // trailing bytes past the form are ignored
            repeat ($urandom_range(0, 2))
                file_bytes.push_back(8'($urandom));

            if (flavour == FILE_CUT_SHORT) begin
                cut = $urandom_range(1, file_bytes.size() - 1);
                while (file_bytes.size() > cut)
                    void'(file_bytes.pop_back());
            end
        end
    endtask

    // wait until the block owes nothing
    task automatic drain_results();
        do @(posedge clk); while (results_due != 0);
    endtask

    // stimulus and verdict
    initial begin
        int files;
        files      = 0;
        bytes_sent = 0;
        in_valid   <= 1'b0;
        in_item    <= '0;
        rst_n      <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // damaged magic, then a minimal file with extreme samples
        file_bytes.delete();
        push_word(TAG_FORM ^ 32'h0000_0003);
        send_file();
        file_bytes.delete();
        push_word(TAG_FORM);
        push_word(32'd14);
        push_word(TAG_8SVX);
        push_word(TAG_BODY);
        push_word(32'd2);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        send_file();

        while (bytes_sent < BYTE_TARGET) begin
            build_file();
            send_file();
            files++;
            // sender holds back until every result is out
            if (files == 10 || files == 25) begin
                in_valid <= 1'b0;
                drain_results();
            end
        end
        in_valid <= 1'b0;

        drain_results();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0 && results_due == 0)
            $display("iff_8svx_stream_parser_core: match");
        else
            $display("iff_8svx_stream_parser_core: mismatch");
        $finish;
    end

    // result side, with two long hold-offs that back the block up
    initial begin
        int gap;
        int calm;
        int taken;
        calm  = 0;
        taken = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            gap = draw_gap(calm);
            if (taken == 150 || taken == 520)
                gap = 80;
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("iff_8svx_stream_parser_core: mismatch");
        $finish;
    end

endmodule

### sim.f
rtl/iff8svx_pkg.sv
rtl/iff_8svx_stream_parser_core.sv
tb/iff_8svx_stream_parser_checker.sv
tb/tb_iff_8svx_stream_parser_core.sv
